// ----- design/ascp_pkg.sv -----
// Shared types and constants for the annular sector point classifier.
// No dependencies; imported by annular_sector_point_classifier.
package ascp_pkg;

  localparam int COORD_BITS_DEF   = 20;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int PT_W             = 20;  // point field width
  localparam int RAD_W            = 20;  // radius register width
  localparam int ANG_W            = 16;  // binary angle width
  localparam int Q14_W            = 16;  // one Q1.14 component
  localparam int CENTRE_W         = 60;
  localparam int VEC_W            = 48;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 64;
  localparam int SIGMA_W          = 16;
  localparam int ATAN_MAX         = 24;

  // isqrt of s*2^16 for s below 2^(2*RAD_W): one result bit per stage
  localparam int SQ_N  = RAD_W + 8;
  // sigma quotient bits, one extra for saturation
  localparam int DIV_N = SIGMA_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTRE   = 3'd0,
    CFG_AXIS     = 3'd1,
    CFG_ZERO_DIR = 3'd2,
    CFG_INNER    = 3'd3,
    CFG_OUTER    = 3'd4,
    CFG_START    = 3'd5,
    CFG_END      = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
    logic signed [PT_W-1:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic               inside_res;
    logic [SIGMA_W-1:0] sigma;
  } out_item_t;

  // truncated atan(2^-i) in 32-bit binary angle units
  localparam logic [31:0] ATAN_TAB [ATAN_MAX] = '{
    32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335086,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41721,     32'd20860,
    32'd10430,     32'd5215,      32'd2607,      32'd1303,
    32'd651,       32'd325,       32'd162,       32'd81
  };

endpackage

// ----- design/annular_sector_point_classifier.sv -----
// Annular sector point classifier: fully pipelined datapath and config registers.
// Depends on ascp_pkg (item structs, register indexes, atan table).
//
// Usage:
//   Input channel: an item (one 3-D point) is taken at each rising edge with
//   start high and busy low. busy is always low, so one point per cycle.
//   Result channel: out_strobe marks out_item for exactly one cycle; every
//   accepted item yields one result, in order. The receiver cannot stall and
//   the pipeline never holds back, so nothing is buffered or dropped.
//   Config channel: cfg_ready is always high; a write lands when cfg_valid is
//   high. Index 7 is ignored. Write config only with the pipeline empty.
//   Throughput: one item per cycle. Depth is set by the projection stages, the
//   CORDIC stages (one rotation each), the bit-per-stage square root (28
//   stages) and the bit-per-stage sigma divider (17 stages).
//   Reset (rst_n low, synchronous) clears all in-flight items and restores
//   the config registers to their defaults.
module annular_sector_point_classifier #(
  parameter int COORD_BITS   = ascp_pkg::COORD_BITS_DEF,
  parameter int CORDIC_STEPS = ascp_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  ascp_pkg::in_item_t                in_item,
  output logic                              out_strobe,
  output ascp_pkg::out_item_t               out_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ascp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ascp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ascp_pkg::*;

  localparam int D_W    = COORD_BITS + 1;
  localparam int PA_W   = D_W + Q14_W;
  localparam int DOT_W  = PA_W + 2;
  localparam int PRD_W  = DOT_W + Q14_W;
  localparam int COR_W  = PRD_W - 28;
  localparam int DP_W   = COR_W + 1;
  localparam int W_W    = 19;
  localparam int PX_W   = DP_W + Q14_W;
  localparam int PY_W   = DP_W + W_W;
  localparam int PS_W   = 2 * DP_W;
  localparam int X_W    = PX_W + 2;
  localparam int Y_W    = PY_W + 2;
  localparam int S_W    = PS_W + 2;
  localparam int CR_W   = Y_W + 2;
  localparam int S2_W   = 2 * RAD_W;
  localparam int RT_W   = SQ_N;
  localparam int RM_W   = SQ_N + 2;
  localparam int SN_W   = 2 * SQ_N;
  localparam int DEN_W  = RAD_W + 8;
  localparam int DR_W   = DEN_W + 1;
  localparam int LAT    = 10 + CORDIC_STEPS + SQ_N + DIV_N;
  localparam logic signed [PRD_W-1:0] RND28 = {{(PRD_W-28){1'b0}}, 1'b1, 27'b0};

  // ---------------- config registers ----------------
  logic [CENTRE_W-1:0]     centre_r;
  logic [VEC_W-1:0]        axis_r, zero_dir_r;
  logic [RAD_W-1:0]        inner_r, outer_r;
  logic signed [ANG_W-1:0] start_r, end_r;

  // config-derived constants, refreshed every cycle
  logic signed [W_W-1:0]   w_r [3];
  logic signed [W_W-1:0]   w_nxt [3];
  logic [S2_W-1:0]         in2_r, out2_r;
  logic [DEN_W-1:0]        den_r;
  logic                    den_nz_r;

  logic signed [Q14_W-1:0] a_c [3];
  logic signed [Q14_W-1:0] z_c [3];
  logic signed [32:0]      wx_c [3];
  logic signed [32:0]      wr_c [3];

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_r   <= '0;
      axis_r     <= VEC_W'(16384);
      zero_dir_r <= VEC_W'(1073741824);
      inner_r    <= '0;
      outer_r    <= '1;
      start_r    <= ANG_W'(-32768);
      end_r      <= ANG_W'(32767);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CENTRE:   centre_r   <= cfg_data[CENTRE_W-1:0];
        CFG_AXIS:     axis_r     <= cfg_data[VEC_W-1:0];
        CFG_ZERO_DIR: zero_dir_r <= cfg_data[VEC_W-1:0];
        CFG_INNER:    inner_r    <= cfg_data[RAD_W-1:0];
        CFG_OUTER:    outer_r    <= cfg_data[RAD_W-1:0];
        CFG_START:    start_r    <= $signed(cfg_data[ANG_W-1:0]);
        CFG_END:      end_r      <= $signed(cfg_data[ANG_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      a_c[k] = $signed(axis_r[(2-k)*Q14_W +: Q14_W]);
      z_c[k] = $signed(zero_dir_r[(2-k)*Q14_W +: Q14_W]);
    end
    // w = zero_dir x axis, back to Q14 with round half up
    wx_c[0] = z_c[1] * a_c[2] - z_c[2] * a_c[1];
    wx_c[1] = z_c[2] * a_c[0] - z_c[0] * a_c[2];
    wx_c[2] = z_c[0] * a_c[1] - z_c[1] * a_c[0];
    for (int k = 0; k < 3; k++) begin
      wr_c[k]  = wx_c[k] + 33'sd8192;
      w_nxt[k] = $signed(wr_c[k][32:14]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) w_r[k] <= w_nxt[k];
    in2_r    <= inner_r * inner_r;
    out2_r   <= outer_r * outer_r;
    den_r    <= {outer_r - inner_r, 8'b0};
    den_nz_r <= outer_r > inner_r;
  end

  // ---------------- valid chain ----------------
  logic [LAT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[LAT-2:0], start && !busy};
  end

  // ---------------- projection stages ----------------
  logic [63:0]                  cen64;
  logic signed [COORD_BITS-1:0] pt_c [3];
  logic signed [COORD_BITS-1:0] cen_c [3];
  logic signed [D_W-1:0]        d1_r [3], d2_r [3], d3_r [3], d4_r [3];
  logic signed [PA_W-1:0]       pa2_r [3];
  logic signed [DOT_W-1:0]      dot3_r;
  logic signed [PRD_W-1:0]      pc4_r [3];
  logic signed [PRD_W-1:0]      rnd_c [3];
  logic signed [DP_W-1:0]       dp5_r [3];
  logic signed [PX_W-1:0]       px6_r [3];
  logic signed [PY_W-1:0]       py6_r [3];
  logic signed [PS_W-1:0]       ps6_r [3];
  logic signed [X_W-1:0]        x7_r;
  logic signed [Y_W-1:0]        y7_r;
  logic [S_W-1:0]               s7_r;

  always_comb begin
    cen64    = {{(64-CENTRE_W){1'b0}}, centre_r};
    pt_c[0]  = COORD_BITS'(in_item.point_x);
    pt_c[1]  = COORD_BITS'(in_item.point_y);
    pt_c[2]  = COORD_BITS'(in_item.point_z);
    for (int k = 0; k < 3; k++) begin
      cen_c[k] = $signed(cen64[(2-k)*COORD_BITS +: COORD_BITS]);
      rnd_c[k] = pc4_r[k] + RND28;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      d1_r[k]  <= D_W'(pt_c[k]) - D_W'(cen_c[k]);
      pa2_r[k] <= d1_r[k] * a_c[k];
      d2_r[k]  <= d1_r[k];
      d3_r[k]  <= d2_r[k];
      pc4_r[k] <= dot3_r * a_c[k];
      d4_r[k]  <= d3_r[k];
      dp5_r[k] <= DP_W'(d4_r[k]) - DP_W'($signed(rnd_c[k][PRD_W-1:28]));
      px6_r[k] <= dp5_r[k] * z_c[k];
      py6_r[k] <= dp5_r[k] * w_r[k];
      ps6_r[k] <= dp5_r[k] * dp5_r[k];
    end
    dot3_r <= DOT_W'(pa2_r[0]) + DOT_W'(pa2_r[1]) + DOT_W'(pa2_r[2]);
    x7_r   <= X_W'(px6_r[0]) + X_W'(px6_r[1]) + X_W'(px6_r[2]);
    y7_r   <= Y_W'(py6_r[0]) + Y_W'(py6_r[1]) + Y_W'(py6_r[2]);
    s7_r   <= S_W'($unsigned(ps6_r[0])) + S_W'($unsigned(ps6_r[1]))
            + S_W'($unsigned(ps6_r[2]));
  end

  // ---------------- CORDIC ----------------
  logic signed [CR_W-1:0] cx_r [0:CORDIC_STEPS];
  logic signed [CR_W-1:0] cy_r [0:CORDIC_STEPS];
  logic [31:0]            cacc_r [0:CORDIC_STEPS];
  logic                   czero_r [0:CORDIC_STEPS];
  logic                   crad_r [0:CORDIC_STEPS];
  logic [S2_W-1:0]        cs_r [0:CORDIC_STEPS];
  logic signed [CR_W-1:0] xe_c, ye_c;

  assign xe_c = CR_W'(x7_r);
  assign ye_c = CR_W'(y7_r);

  // quadrant fold into the right half plane
  always_ff @(posedge clk) begin
    if (xe_c < 0) begin
      if (ye_c >= 0) begin
        cx_r[0]   <= ye_c;
        cy_r[0]   <= -xe_c;
        cacc_r[0] <= 32'h4000_0000;
      end else begin
        cx_r[0]   <= -ye_c;
        cy_r[0]   <= xe_c;
        cacc_r[0] <= 32'hC000_0000;
      end
    end else begin
      cx_r[0]   <= xe_c;
      cy_r[0]   <= ye_c;
      cacc_r[0] <= '0;
    end
    czero_r[0] <= (x7_r == 0) && (y7_r == 0);
    crad_r[0]  <= (s7_r >= S_W'(in2_r)) && (s7_r <= S_W'(out2_r));
    cs_r[0]    <= s7_r[S2_W-1:0];
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [CR_W-1:0] xs_c, ys_c;
    assign xs_c = cx_r[i] >>> i;
    assign ys_c = cy_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (cy_r[i] > 0) begin
        cx_r[i+1]   <= cx_r[i] + ys_c;
        cy_r[i+1]   <= cy_r[i] - xs_c;
        cacc_r[i+1] <= cacc_r[i] + ATAN_TAB[i];
      end else begin
        cx_r[i+1]   <= cx_r[i] - ys_c;
        cy_r[i+1]   <= cy_r[i] + xs_c;
        cacc_r[i+1] <= cacc_r[i] - ATAN_TAB[i];
      end
      czero_r[i+1] <= czero_r[i];
      crad_r[i+1]  <= crad_r[i];
      cs_r[i+1]    <= cs_r[i];
    end
  end

  // ---------------- arc test, square root ----------------
  logic [31:0]             acc_rnd_c;
  logic signed [ANG_W-1:0] ang_c;
  logic                    arc_c;
  logic [RM_W-1:0]         sq_rem_r [0:SQ_N];
  logic [RT_W-1:0]         sq_root_r [0:SQ_N];
  logic [SN_W-1:0]         sq_n_r [0:SQ_N];
  logic                    sq_ins_r [0:SQ_N];

  always_comb begin
    acc_rnd_c = cacc_r[CORDIC_STEPS] + 32'h0000_8000;
    ang_c     = czero_r[CORDIC_STEPS] ? '0 : $signed(acc_rnd_c[31:16]);
    // start not below end: arc wraps through +-180
    if (start_r < end_r) arc_c = (ang_c >= start_r) && (ang_c <= end_r);
    else                 arc_c = (ang_c >= start_r) || (ang_c <= end_r);
  end

  always_ff @(posedge clk) begin
    sq_rem_r[0]  <= '0;
    sq_root_r[0] <= '0;
    sq_n_r[0]    <= {cs_r[CORDIC_STEPS], {(SN_W-S2_W){1'b0}}};
    sq_ins_r[0]  <= crad_r[CORDIC_STEPS] && arc_c;
  end

  for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
    logic [RM_W+1:0] rt_c, tr_c;
    assign rt_c = {sq_rem_r[j], sq_n_r[j][SN_W-1:SN_W-2]};
    assign tr_c = (RM_W+2)'({sq_root_r[j], 2'b01});
    always_ff @(posedge clk) begin
      if (rt_c >= tr_c) begin
        sq_rem_r[j+1]  <= RM_W'(rt_c - tr_c);
        sq_root_r[j+1] <= {sq_root_r[j][RT_W-2:0], 1'b1};
      end else begin
        sq_rem_r[j+1]  <= RM_W'(rt_c);
        sq_root_r[j+1] <= {sq_root_r[j][RT_W-2:0], 1'b0};
      end
      sq_n_r[j+1]   <= {sq_n_r[j][SN_W-3:0], 2'b00};
      sq_ins_r[j+1] <= sq_ins_r[j];
    end
  end

  // ---------------- sigma divider ----------------
  logic [DR_W-1:0]  dv_rem_r [1:DIV_N];
  logic [DIV_N-1:0] dv_q_r [1:DIV_N];
  logic             dv_ins_r [1:DIV_N];
  logic [RT_W-1:0]  num_c;

  assign num_c = sq_root_r[SQ_N] - {inner_r, 8'b0};

  for (genvar k = 0; k < DIV_N; k++) begin : g_div
    logic [DR_W-1:0]  r_c;
    logic [DIV_N-1:0] q_c;
    logic             ins_c;
    if (k == 0) begin : g_first
      assign r_c   = DR_W'(num_c);
      assign q_c   = '0;
      assign ins_c = sq_ins_r[SQ_N];
    end else begin : g_next
      assign r_c   = {dv_rem_r[k][DR_W-2:0], 1'b0};
      assign q_c   = dv_q_r[k];
      assign ins_c = dv_ins_r[k];
    end
    always_ff @(posedge clk) begin
      if (r_c >= DR_W'(den_r)) begin
        dv_rem_r[k+1] <= r_c - DR_W'(den_r);
        dv_q_r[k+1]   <= {q_c[DIV_N-2:0], 1'b1};
      end else begin
        dv_rem_r[k+1] <= r_c;
        dv_q_r[k+1]   <= {q_c[DIV_N-2:0], 1'b0};
      end
      dv_ins_r[k+1] <= ins_c;
    end
  end

  // ---------------- output register ----------------
  out_item_t out_r, out_nxt;

  always_comb begin
    out_nxt.inside_res = dv_ins_r[DIV_N];
    out_nxt.sigma      = '0;
    if (dv_ins_r[DIV_N] && den_nz_r) begin
      out_nxt.sigma = dv_q_r[DIV_N][DIV_N-1] ? '1 : dv_q_r[DIV_N][SIGMA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_item   = out_r;
  assign out_strobe = vld_r[LAT-1];

`ifndef SYNTHESIS
  a_lat_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_strobe)
    else $error("accepted item did not reach the output on time");
  a_lat_none: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##LAT !out_strobe)
    else $error("result strobe without a matching accepted item");
  a_sigma_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_item.inside_res) |-> (out_item.sigma == '0))
    else $error("nonzero sigma for a point outside the sector");
`endif

endmodule

// ----- tb/tb.sv -----
// Testbench for annular_sector_point_classifier: directed and random points, checked
// against an in-bench predictor over several register settings.
// Depends on ascp_pkg and the RTL top level; needs no files of its own.
`timescale 1ns / 100ps

module tb;
  import ascp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 120;
  localparam int PHASES = 8;
  localparam int PTS_PER_PHASE = 86;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_strobe;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor copy of the registers
  logic [59:0] centre_r;
  logic [47:0] axis_r, zdir_r;
  logic [19:0] inner_r, outer_r;
  logic signed [15:0] start_r, end_r;

  out_item_t expected_q[$];
  int errors = 0;
  int quiet = 0;
  bit no_gaps = 0;

  typedef struct {
    logic signed [PT_W-1:0] x, y, z;
    bit typed;
    out_item_t res;
  } point_row_t;

  // rows against the reset settings: axis z, zero direction y, full circle
  point_row_t directed[] = '{
    '{20'sd0, 20'sd0, 20'sd0, 1'b1, '{1'b1, 16'd0}},
    '{20'sd0, 20'sd0, 20'sd524287, 1'b1, '{1'b1, 16'd0}},
    '{20'sd0, 20'sd0, -20'sd524288, 1'b1, '{1'b1, 16'd0}},
    '{20'sd524287, 20'sd524287, 20'sd524287, 1'b0, '0},
    '{-20'sd524288, -20'sd524288, -20'sd524288, 1'b0, '0},
    '{20'sd524287, -20'sd524288, 20'sd0, 1'b0, '0},
    '{-20'sd524288, 20'sd524287, -20'sd1, 1'b0, '0},
    '{20'sd1, 20'sd0, 20'sd0, 1'b0, '0},
    '{20'sd0, 20'sd1, 20'sd0, 1'b0, '0},
    '{-20'sd1, 20'sd0, 20'sd0, 1'b0, '0},
    '{20'sd0, -20'sd1, 20'sd0, 1'b0, '0},
    '{-20'sd1000, 20'sd0, 20'sd77, 1'b0, '0},
    '{20'sd0, -20'sd524288, 20'sd5, 1'b0, '0},
    '{-20'sd524288, -20'sd1, 20'sd0, 1'b0, '0},
    '{20'sd300000, 20'sd300000, 20'sd0, 1'b0, '0}
  };

  annular_sector_point_classifier dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void reset_regs();
    centre_r = '0;
    axis_r = 48'd16384;
    zdir_r = 48'd1073741824;
    inner_r = '0;
    outer_r = 20'hFFFFF;
    start_r = -16'sd32768;
    end_r = 16'sd32767;
  endfunction

  function automatic void store_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    case (idx)
      CFG_CENTRE:   centre_r = v[59:0];
      CFG_AXIS:     axis_r = v[47:0];
      CFG_ZERO_DIR: zdir_r = v[47:0];
      CFG_INNER:    inner_r = v[19:0];
      CFG_OUTER:    outer_r = v[19:0];
      CFG_START:    start_r = v[15:0];
      CFG_END:      end_r = v[15:0];
      default: ;
    endcase
  endfunction

  function automatic longint round_q(longint v, int k);
    return (v + (longint'(1) << (k - 1))) >>> k;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] polar_angle(longint x, longint y);
    logic [31:0] acc, rnd;
    longint t, xs, ys;
    acc = '0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; acc = 32'h4000_0000;
      end else begin
        x = -y; y = t; acc = 32'hC000_0000;
      end
    end
    for (int i = 0; i < CORDIC_STEPS_DEF && i < ATAN_MAX; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; acc = acc + ATAN_TAB[i];
      end else begin
        x = x - ys; y = y + xs; acc = acc - ATAN_TAB[i];
      end
    end
    rnd = acc + 32'h8000;
    return rnd[31:16];
  endfunction

  function automatic out_item_t classify_point(in_item_t p);
    longint a[3], zd[3], w[3], d[3], dot, cx, cy, cz, xx, yy;
    longint unsigned s, dist8, num, den, sig;
    logic signed [15:0] ang;
    bit in_rad, in_arc;
    out_item_t r;
    a[0] = $signed(axis_r[47:32]); a[1] = $signed(axis_r[31:16]);
    a[2] = $signed(axis_r[15:0]);
    zd[0] = $signed(zdir_r[47:32]); zd[1] = $signed(zdir_r[31:16]);
    zd[2] = $signed(zdir_r[15:0]);
    cx = $signed(centre_r[59:40]); cy = $signed(centre_r[39:20]);
    cz = $signed(centre_r[19:0]);
    d[0] = longint'(p.point_x) - cx;
    d[1] = longint'(p.point_y) - cy;
    d[2] = longint'(p.point_z) - cz;
    dot = d[0] * a[0] + d[1] * a[1] + d[2] * a[2];
    for (int k = 0; k < 3; k++) d[k] = d[k] - round_q(dot * a[k], 28);
    w[0] = round_q(zd[1] * a[2] - zd[2] * a[1], 14);
    w[1] = round_q(zd[2] * a[0] - zd[0] * a[2], 14);
    w[2] = round_q(zd[0] * a[1] - zd[1] * a[0], 14);
    xx = d[0] * zd[0] + d[1] * zd[1] + d[2] * zd[2];
    yy = d[0] * w[0] + d[1] * w[1] + d[2] * w[2];
    ang = polar_angle(xx, yy);
    s = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
    in_rad = s >= longint'(inner_r) * inner_r && s <= longint'(outer_r) * outer_r;
    if (start_r < end_r) in_arc = start_r <= ang && ang <= end_r;
    else in_arc = start_r <= ang || ang <= end_r;
    sig = 0;
    if (in_rad && in_arc && outer_r > inner_r) begin
      dist8 = int_sqrt(s << 16);
      num = dist8 - longint'(inner_r) * 256;
      den = longint'(outer_r - inner_r) * 256;
      sig = (num << 16) / den;
      if (sig > 65535) sig = 65535;
    end
    r.inside_res = in_rad && in_arc;
    r.sigma = sig[15:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // leaves cfg_valid high; caller lowers it after the last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    store_reg(idx, v);
  endtask

  // leaves start high; caller lowers it when the stream ends
  task automatic send_point(in_item_t p, bit typed, out_item_t res);
    int g;
    start <= 1'b1;
    in_item <= p;
    do @(posedge clk); while (busy);
    expected_q.push_back(typed ? res : classify_point(p));
    g = pick_gap();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [15:0] unit_vec(int unsigned sel);
    case (sel % 6)
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sd11585;
      3: return -16'sd11585;
      4: return 16'sd0;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic configure(int mode);
    logic [CFG_DATA_W-1:0] v[7];
    int unsigned sel;
    logic [19:0] inr, outr;
    sel = $urandom_range(0, 2);
    v[CFG_CENTRE] = 64'({20'($signed($urandom_range(0, 4000)) - 2000),
                         20'($signed($urandom_range(0, 4000)) - 2000),
                         20'($signed($urandom_range(0, 4000)) - 2000)});
    case (sel)
      0: begin v[CFG_AXIS] = 64'({16'd0, 16'd0, 16'sd16384});
         v[CFG_ZERO_DIR] = 64'({16'sd16384, 16'd0, 16'd0}); end
      1: begin v[CFG_AXIS] = 64'({16'sd16384, 16'd0, 16'd0});
         v[CFG_ZERO_DIR] = 64'({16'd0, 16'd0, -16'sd16384}); end
      default: begin v[CFG_AXIS] = 64'({16'sd11585, 16'sd11585, 16'd0});
         v[CFG_ZERO_DIR] = 64'({16'd0, 16'd0, 16'sd16384}); end
    endcase
    inr = 20'($urandom_range(0, 100000));
    outr = 20'(inr + $urandom_range(1, 300000));
    v[CFG_START] = 64'($signed(16'($urandom)));
    v[CFG_END] = 64'($signed(16'($urandom)));
    case (mode)
      2: outr = inr;
      3: begin outr = inr; inr = 20'(inr + $urandom_range(1, 5000)); end
      4: begin
        v[CFG_CENTRE] = {$urandom, $urandom};
        v[CFG_AXIS] = {$urandom, $urandom};
        v[CFG_ZERO_DIR] = {$urandom, $urandom};
        inr = 20'($urandom); outr = 20'($urandom);
      end
      5: v[CFG_END] = v[CFG_START];
      6: begin
        v[CFG_CENTRE] = 64'({20'h7FFFF, 20'h80000, 20'h7FFFF});
        inr = '0; outr = 20'hFFFFF;
        v[CFG_START] = 64'sd32767; v[CFG_END] = -64'sd32768;
      end
      7: begin
        v[CFG_AXIS] = 64'({unit_vec($urandom), unit_vec($urandom), unit_vec($urandom)});
        v[CFG_ZERO_DIR] = 64'({unit_vec($urandom), unit_vec($urandom),
                               unit_vec($urandom)});
        v[CFG_START] = -64'sd32768; v[CFG_END] = 64'sd32767;
      end
      default: ;
    endcase
    v[CFG_INNER] = {$urandom, 12'h000, inr};
    v[CFG_OUTER] = {$urandom, 12'h000, outr};
    for (int i = 0; i < 7; i++) write_reg(CFG_IDX_W'(i), v[i]);
    if (mode == 1) write_reg(CFG_UNUSED, {$urandom, $urandom});
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int near_offset();
    return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
  endfunction

  function automatic in_item_t random_point();
    in_item_t p;
    if ($urandom_range(0, 1)) begin
      p = 60'({$urandom, $urandom});
    end else begin
      p.point_x = PT_W'($signed(centre_r[59:40]) + near_offset());
      p.point_y = PT_W'($signed(centre_r[39:20]) + near_offset());
      p.point_z = PT_W'($signed(centre_r[19:0]) + near_offset());
    end
    return p;
  endfunction

  // result checker and watchdog
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
      if (out_strobe) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_item);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (out_item.inside_res !== want.inside_res) begin
            $display("%0t: inside_res expected %0b got %0b", $time, want.inside_res,
                     out_item.inside_res);
            errors++;
          end
          if (out_item.sigma !== want.sigma) begin
            $display("%0t: sigma expected %0d got %0d", $time, want.sigma, out_item.sigma);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    in_item_t p;
    reset_regs();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) begin
      p.point_x = directed[i].x;
      p.point_y = directed[i].y;
      p.point_z = directed[i].z;
      send_point(p, directed[i].typed, directed[i].res);
    end
    for (int i = 0; i < PTS_PER_PHASE; i++) send_point(random_point(), 1'b0, '0);
    start <= 1'b0;
    for (int m = 1; m < PHASES; m++) begin
      wait_drained();
      configure(m);
      no_gaps = (m % 3 == 0);
      for (int i = 0; i < PTS_PER_PHASE; i++) send_point(random_point(), 1'b0, '0);
      start <= 1'b0;
    end
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
